// ===== design/rba_pkg.sv =====
package rba_pkg;

	// CORDIC angle format: 2^32 units per turn, residual kept in Q30
	localparam int ANG_W        = 32;
	localparam int CORDIC_STEPS = 20;
	localparam int CX_W         = 33;
	localparam int CZ_W         = 33;
	localparam int CS_W         = 32;
	localparam int Q30          = 30;

	// rotation matrix entries in Q24
	localparam int MAT_FRAC  = 24;
	localparam int MAT_W     = 28;
	localparam int MAT_SHIFT = Q30 - MAT_FRAC;

	localparam logic signed [CX_W-1:0] CORDIC_GAIN = 33'sd652032874;

	localparam logic signed [CZ_W-1:0] ATAN_UNITS [CORDIC_STEPS] = '{
		33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756, 33'sd42667331,
		33'sd21354465,  33'sd10679838,  33'sd5340245,   33'sd2670163,  33'sd1335087,
		33'sd667544,    33'sd333772,    33'sd166886,    33'sd83443,    33'sd41722,
		33'sd20861,     33'sd10430,     33'sd5215,      33'sd2608,     33'sd1304
	};

	typedef logic signed [CS_W-1:0]   trig_t;
	typedef logic signed [MAT_W-1:0]  mat_t;
	typedef logic signed [2*CS_W-1:0] prod_t;

	// round a Q30 x Q30 product half up back to Q30
	function automatic trig_t q30_round(input prod_t p);
		prod_t t;
		t = p + (prod_t'(1) <<< (Q30 - 1));
		return trig_t'(t >>> Q30);
	endfunction

	// round a Q30 matrix term half up to Q24
	function automatic mat_t mat_round(input logic signed [CS_W:0] v);
		logic signed [CS_W+1:0] t;
		t = $signed({v[CS_W], v}) + (CS_W+2)'(1 <<< (MAT_SHIFT - 1));
		return mat_t'(t >>> MAT_SHIFT);
	endfunction

endpackage

// ===== design/rba_cordic.sv =====
module rba_cordic import rba_pkg::*; #(
	parameter int COORD_WIDTH = 21,
	parameter int SIDE_W      = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  logic [3*COORD_WIDTH-1:0]   angles,
	input  logic [SIDE_W-1:0]          side_in,
	output logic                       out_vld,
	output trig_t                      cos_o [3],
	output trig_t                      sin_o [3],
	output logic [SIDE_W-1:0]          side_out
);

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	logic                   vld_s  [CORDIC_STEPS];
	logic signed [CX_W-1:0] x_s    [CORDIC_STEPS][3];
	logic signed [CX_W-1:0] y_s    [CORDIC_STEPS][3];
	logic signed [CZ_W-1:0] z_s    [CORDIC_STEPS][3];
	logic [1:0]             quad_s [CORDIC_STEPS][3];
	logic [SIDE_W-1:0]      side_s [CORDIC_STEPS];

	logic [ANG_W-1:0]       full_a [3];
	logic signed [CZ_W-1:0] ent_z  [3];
	logic [1:0]             ent_q  [3];

	// widen each angle to 2^32 units, split quadrant and residual
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			full_a[a] = ANG_W'(angles[a*COORD_WIDTH +: COORD_WIDTH]) << (ANG_W - COORD_WIDTH);
			ent_z[a]  = CZ_W'(full_a[a][ANG_W-3:0]);
			ent_q[a]  = full_a[a][ANG_W-1:ANG_W-2];
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin: g_step
		logic                   vi;
		logic [SIDE_W-1:0]      si;
		logic signed [CX_W-1:0] xi [3];
		logic signed [CX_W-1:0] yi [3];
		logic signed [CZ_W-1:0] zi [3];
		logic [1:0]             qi [3];
		logic signed [CX_W-1:0] xn [3];
		logic signed [CX_W-1:0] yn [3];
		logic signed [CZ_W-1:0] zn [3];

		if (i == 0) begin: g_src
			always_comb begin
				vi = in_vld;
				si = side_in;
				for (int a = 0; a < 3; a++) begin
					xi[a] = CORDIC_GAIN;
					yi[a] = '0;
					zi[a] = ent_z[a];
					qi[a] = ent_q[a];
				end
			end
		end else begin: g_src
			always_comb begin
				vi = vld_s[i-1];
				si = side_s[i-1];
				for (int a = 0; a < 3; a++) begin
					xi[a] = x_s[i-1][a];
					yi[a] = y_s[i-1][a];
					zi[a] = z_s[i-1][a];
					qi[a] = quad_s[i-1][a];
				end
			end
		end

		// rotate toward zero residual
		always_comb begin
			for (int a = 0; a < 3; a++) begin
				if (zi[a] >= 0) begin
					xn[a] = xi[a] - (yi[a] >>> i);
					yn[a] = yi[a] + (xi[a] >>> i);
					zn[a] = zi[a] - ATAN_UNITS[i];
				end else begin
					xn[a] = xi[a] + (yi[a] >>> i);
					yn[a] = yi[a] - (xi[a] >>> i);
					zn[a] = zi[a] + ATAN_UNITS[i];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i] <= si;
				for (int a = 0; a < 3; a++) begin
					x_s[i][a]    <= xn[a];
					y_s[i][a]    <= yn[a];
					z_s[i][a]    <= zn[a];
					quad_s[i][a] <= qi[a];
				end
			end
		end
	end

	// map the residual result back to its quadrant
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= vld_s[CORDIC_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_out <= side_s[CORDIC_STEPS-1];
			for (int a = 0; a < 3; a++) begin
				unique case (quad_s[CORDIC_STEPS-1][a])
					QUAD_0: begin
						cos_o[a] <= trig_t'(x_s[CORDIC_STEPS-1][a]);
						sin_o[a] <= trig_t'(y_s[CORDIC_STEPS-1][a]);
					end
					QUAD_1: begin
						cos_o[a] <= trig_t'(-y_s[CORDIC_STEPS-1][a]);
						sin_o[a] <= trig_t'(x_s[CORDIC_STEPS-1][a]);
					end
					QUAD_2: begin
						cos_o[a] <= trig_t'(-x_s[CORDIC_STEPS-1][a]);
						sin_o[a] <= trig_t'(-y_s[CORDIC_STEPS-1][a]);
					end
					QUAD_3: begin
						cos_o[a] <= trig_t'(y_s[CORDIC_STEPS-1][a]);
						sin_o[a] <= trig_t'(-x_s[CORDIC_STEPS-1][a]);
					end
					default: begin
						cos_o[a] <= trig_t'(x_s[CORDIC_STEPS-1][a]);
						sin_o[a] <= trig_t'(y_s[CORDIC_STEPS-1][a]);
					end
				endcase
			end
		end
	end

endmodule

// ===== design/rba_matrix.sv =====
module rba_matrix import rba_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  trig_t             cos_i [3],
	input  trig_t             sin_i [3],
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_vld,
	output mat_t              mat_o [9],
	output logic [SIDE_W-1:0] side_out
);

	// angle index: 0 alpha, 1 beta, 2 gamma; matrix index row*3+col
	logic              vld_s1, vld_s2, vld_s3;
	logic [SIDE_W-1:0] side_s1, side_s2, side_s3;
	prod_t             p_s1 [10];
	trig_t             ca_s1, sa_s1, sb_s1;
	trig_t             q_s2 [10];
	trig_t             ca_s2, sa_s2, sb_s2;
	prod_t             p_s3 [4];
	trig_t             q_s3 [8];
	trig_t             sb_s3;

	logic signed [CS_W:0] e [9];
	trig_t                r3 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			out_vld <= vld_s3;
		end
	end

	// products of two trig terms, then rounded, then the triple products, then the Q24 entries
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			ca_s1   <= cos_i[0];
			sa_s1   <= sin_i[0];
			sb_s1   <= sin_i[1];
			p_s1[0] <= prod_t'(cos_i[0]) * prod_t'(cos_i[1]);
			p_s1[1] <= prod_t'(sin_i[0]) * prod_t'(cos_i[1]);
			p_s1[2] <= prod_t'(sin_i[0]) * prod_t'(cos_i[2]);
			p_s1[3] <= prod_t'(cos_i[0]) * prod_t'(cos_i[2]);
			p_s1[4] <= prod_t'(cos_i[1]) * prod_t'(sin_i[2]);
			p_s1[5] <= prod_t'(sin_i[0]) * prod_t'(sin_i[2]);
			p_s1[6] <= prod_t'(cos_i[0]) * prod_t'(sin_i[2]);
			p_s1[7] <= prod_t'(cos_i[1]) * prod_t'(cos_i[2]);
			p_s1[8] <= prod_t'(sin_i[1]) * prod_t'(sin_i[2]);
			p_s1[9] <= prod_t'(sin_i[1]) * prod_t'(cos_i[2]);

			side_s2 <= side_s1;
			ca_s2   <= ca_s1;
			sa_s2   <= sa_s1;
			sb_s2   <= sb_s1;
			for (int k = 0; k < 10; k++) begin
				q_s2[k] <= q30_round(p_s1[k]);
			end

			side_s3 <= side_s2;
			sb_s3   <= sb_s2;
			p_s3[0] <= prod_t'(ca_s2) * prod_t'(q_s2[8]);
			p_s3[1] <= prod_t'(sa_s2) * prod_t'(q_s2[8]);
			p_s3[2] <= prod_t'(ca_s2) * prod_t'(q_s2[9]);
			p_s3[3] <= prod_t'(sa_s2) * prod_t'(q_s2[9]);
			for (int k = 0; k < 8; k++) begin
				q_s3[k] <= q_s2[k];
			end

			side_out <= side_s3;
			for (int k = 0; k < 9; k++) begin
				mat_o[k] <= mat_round(e[k]);
			end
		end
	end

	// combine into the nine Q30 entries
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			r3[k] = q30_round(p_s3[k]);
		end
		e[0] = $signed({q_s3[0][CS_W-1], q_s3[0]});
		e[3] = $signed({q_s3[1][CS_W-1], q_s3[1]});
		e[6] = -$signed({sb_s3[CS_W-1], sb_s3});
		e[1] = $signed({r3[0][CS_W-1], r3[0]}) - $signed({q_s3[2][CS_W-1], q_s3[2]});
		e[4] = $signed({r3[1][CS_W-1], r3[1]}) + $signed({q_s3[3][CS_W-1], q_s3[3]});
		e[7] = $signed({q_s3[4][CS_W-1], q_s3[4]});
		e[2] = $signed({r3[2][CS_W-1], r3[2]}) + $signed({q_s3[5][CS_W-1], q_s3[5]});
		e[5] = $signed({r3[3][CS_W-1], r3[3]}) - $signed({q_s3[6][CS_W-1], q_s3[6]});
		e[8] = $signed({q_s3[7][CS_W-1], q_s3[7]});
	end

endmodule

// ===== design/rba_bounds.sv =====
module rba_bounds import rba_pkg::*; #(
	parameter int COORD_WIDTH = 21,
	parameter int FRAC_BITS   = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_vld,
	input  mat_t                          mat_i [9],
	input  logic [3*COORD_WIDTH-1:0]      lower,
	input  logic [3*COORD_WIDTH-1:0]      upper,
	input  logic [3*COORD_WIDTH-1:0]      scale,
	input  logic [3*COORD_WIDTH-1:0]      pos,
	output logic                          out_vld,
	output logic signed [COORD_WIDTH-1:0] lo_o [3],
	output logic signed [COORD_WIDTH-1:0] hi_o [3]
);

	localparam int PW = 2 * COORD_WIDTH;
	localparam int HW = MAT_W + COORD_WIDTH + 1;
	localparam int AW = MAT_W + PW;
	localparam int SW = AW + 2;
	localparam int LW = SW - MAT_FRAC;
	localparam logic signed [LW:0] SAT_HI = (LW+1)'((1 <<< (COORD_WIDTH - 1)) - 1);
	localparam logic signed [LW:0] SAT_LO = -SAT_HI - (LW+1)'(1);

	logic                    vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic signed [PW-1:0]    plo_s1 [3], pup_s1 [3];
	logic signed [PW-1:0]    plo_s2 [3], pup_s2 [3];
	mat_t                    m_s1 [9], m_s2 [9];
	logic signed [HW-1:0]    ph_s3 [18], pl_s3 [18];
	logic signed [AW-1:0]    a_s4 [18];
	logic signed [AW-1:0]    mn_s5 [9], mx_s5 [9];
	logic signed [LW-1:0]    lowb_s6 [3], highb_s6 [3];
	logic [3*COORD_WIDTH-1:0] pos_s1, pos_s2, pos_s3, pos_s4, pos_s5, pos_s6;

	logic signed [COORD_WIDTH-1:0] ph_c [18];
	logic signed [COORD_WIDTH:0]   pl_c [18];
	logic signed [SW-1:0]          slo [3], shi [3];
	logic signed [LW:0]            tlo [3], thi [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			out_vld <= vld_s6;
		end
	end

	// split each scaled corner component into a signed high and unsigned low half
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				ph_c[(r*3+c)*2]   = plo_s2[c][PW-1:COORD_WIDTH];
				pl_c[(r*3+c)*2]   = $signed({1'b0, plo_s2[c][COORD_WIDTH-1:0]});
				ph_c[(r*3+c)*2+1] = pup_s2[c][PW-1:COORD_WIDTH];
				pl_c[(r*3+c)*2+1] = $signed({1'b0, pup_s2[c][COORD_WIDTH-1:0]});
			end
		end
	end

	// row sums of the per-column extremes, rounded to coordinates; then add position
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			slo[r] = SW'(mn_s5[r*3]) + SW'(mn_s5[r*3+1]) + SW'(mn_s5[r*3+2])
				+ (SW'(1) <<< (MAT_FRAC - 1));
			shi[r] = SW'(mx_s5[r*3]) + SW'(mx_s5[r*3+1]) + SW'(mx_s5[r*3+2])
				+ (SW'(1) <<< (MAT_FRAC - 1));
			tlo[r] = (LW+1)'(lowb_s6[r])
				+ (LW+1)'($signed(pos_s6[r*COORD_WIDTH +: COORD_WIDTH]));
			thi[r] = (LW+1)'(highb_s6[r])
				+ (LW+1)'($signed(pos_s6[r*COORD_WIDTH +: COORD_WIDTH]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// scale both corners per axis
			pos_s1 <= pos;
			for (int k = 0; k < 9; k++) begin
				m_s1[k] <= mat_i[k];
			end
			for (int c = 0; c < 3; c++) begin
				plo_s1[c] <= PW'($signed(scale[c*COORD_WIDTH +: COORD_WIDTH]))
					* PW'($signed(lower[c*COORD_WIDTH +: COORD_WIDTH]));
				pup_s1[c] <= PW'($signed(scale[c*COORD_WIDTH +: COORD_WIDTH]))
					* PW'($signed(upper[c*COORD_WIDTH +: COORD_WIDTH]));
			end

			// round the scaled components
			pos_s2 <= pos_s1;
			for (int k = 0; k < 9; k++) begin
				m_s2[k] <= m_s1[k];
			end
			for (int c = 0; c < 3; c++) begin
				plo_s2[c] <= (plo_s1[c] + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
				pup_s2[c] <= (pup_s1[c] + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
			end

			// partial products of matrix entry and component halves
			pos_s3 <= pos_s2;
			for (int j = 0; j < 18; j++) begin
				ph_s3[j] <= HW'(m_s2[j/2]) * HW'(ph_c[j]);
				pl_s3[j] <= HW'(m_s2[j/2]) * HW'(pl_c[j]);
			end

			// join the halves
			pos_s4 <= pos_s3;
			for (int j = 0; j < 18; j++) begin
				a_s4[j] <= (AW'(ph_s3[j]) <<< COORD_WIDTH) + AW'(pl_s3[j]);
			end

			// per-term extremes over the two corners
			pos_s5 <= pos_s4;
			for (int k = 0; k < 9; k++) begin
				mn_s5[k] <= (a_s4[2*k] < a_s4[2*k+1]) ? a_s4[2*k] : a_s4[2*k+1];
				mx_s5[k] <= (a_s4[2*k] > a_s4[2*k+1]) ? a_s4[2*k] : a_s4[2*k+1];
			end

			pos_s6 <= pos_s5;
			for (int r = 0; r < 3; r++) begin
				lowb_s6[r]  <= LW'(slo[r] >>> MAT_FRAC);
				highb_s6[r] <= LW'(shi[r] >>> MAT_FRAC);
			end

			// saturate to the coordinate range
			for (int r = 0; r < 3; r++) begin
				if (tlo[r] > SAT_HI) begin
					lo_o[r] <= COORD_WIDTH'(SAT_HI);
				end else if (tlo[r] < SAT_LO) begin
					lo_o[r] <= COORD_WIDTH'(SAT_LO);
				end else begin
					lo_o[r] <= COORD_WIDTH'(tlo[r]);
				end
				if (thi[r] > SAT_HI) begin
					hi_o[r] <= COORD_WIDTH'(SAT_HI);
				end else if (thi[r] < SAT_LO) begin
					hi_o[r] <= COORD_WIDTH'(SAT_LO);
				end else begin
					hi_o[r] <= COORD_WIDTH'(thi[r]);
				end
			end
		end
	end

endmodule

// ===== design/rotated_box_aabb.sv =====
// An accepted input beat reaches its result beat through the registered stages
// (20 CORDIC steps plus quadrant map, 4 matrix stages, 7 bounds stages).
// Throughput: one box per cycle unless the output stalls; every CORDIC step has its own stage, no multiplier is shared.
// A held result beat freezes the whole pipeline; in_stall follows it in the same cycle.
// Reset (arst_n low) clears all valid bits at once; data registers are not reset.
module rotated_box_aabb import rba_pkg::*; #(
	parameter int COORD_WIDTH = 21,
	parameter int FRAC_BITS   = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [62:0]                   model_lower,
	input  logic [62:0]                   model_upper,
	input  logic [62:0]                   rotation_angles,
	input  logic [62:0]                   scale_factors,
	input  logic [62:0]                   position_offset,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] box_min_x,
	output logic signed [COORD_WIDTH-1:0] box_min_y,
	output logic signed [COORD_WIDTH-1:0] box_min_z,
	output logic signed [COORD_WIDTH-1:0] box_max_x,
	output logic signed [COORD_WIDTH-1:0] box_max_y,
	output logic signed [COORD_WIDTH-1:0] box_max_z
);

	localparam int FW     = 3 * COORD_WIDTH;
	localparam int SIDE_W = 4 * FW;

	logic              en;
	logic              cor_vld, mat_vld;
	trig_t             cos_v [3], sin_v [3];
	mat_t              mat_v [9];
	logic [SIDE_W-1:0] side_in, side_cor, side_mat;
	logic signed [COORD_WIDTH-1:0] lo_v [3], hi_v [3];

	// advance unless a finished beat is held at the output
	assign in_stall = out_valid & out_stall;
	assign en       = ~in_stall;

	assign side_in = {position_offset[FW-1:0], scale_factors[FW-1:0],
		model_upper[FW-1:0], model_lower[FW-1:0]};

	rba_cordic #(
		.COORD_WIDTH(COORD_WIDTH),
		.SIDE_W     (SIDE_W)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (in_valid),
		.angles  (rotation_angles[FW-1:0]),
		.side_in (side_in),
		.out_vld (cor_vld),
		.cos_o   (cos_v),
		.sin_o   (sin_v),
		.side_out(side_cor)
	);

	rba_matrix #(
		.SIDE_W(SIDE_W)
	) u_matrix (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (cor_vld),
		.cos_i   (cos_v),
		.sin_i   (sin_v),
		.side_in (side_cor),
		.out_vld (mat_vld),
		.mat_o   (mat_v),
		.side_out(side_mat)
	);

	rba_bounds #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_bounds (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (mat_vld),
		.mat_i  (mat_v),
		.lower  (side_mat[FW-1:0]),
		.upper  (side_mat[2*FW-1:FW]),
		.scale  (side_mat[3*FW-1:2*FW]),
		.pos    (side_mat[4*FW-1:3*FW]),
		.out_vld(out_valid),
		.lo_o   (lo_v),
		.hi_o   (hi_v)
	);

	assign box_min_x = lo_v[0];
	assign box_min_y = lo_v[1];
	assign box_min_z = lo_v[2];
	assign box_max_x = hi_v[0];
	assign box_max_y = hi_v[1];
	assign box_max_z = hi_v[2];

endmodule

// ===== design/rba_check.sv =====
module rba_check #(
	parameter int COORD_WIDTH = 21
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [COORD_WIDTH-1:0] box_min_x,
	input logic signed [COORD_WIDTH-1:0] box_min_y,
	input logic signed [COORD_WIDTH-1:0] box_min_z,
	input logic signed [COORD_WIDTH-1:0] box_max_x,
	input logic signed [COORD_WIDTH-1:0] box_max_y,
	input logic signed [COORD_WIDTH-1:0] box_max_z
);

	// a held result beat stays valid
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while held");

	// a held result beat keeps its bounds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(box_min_x) && $stable(box_max_x)
			&& $stable(box_min_y) && $stable(box_max_y)
			&& $stable(box_min_z) && $stable(box_max_z))
		else $error("held result beat changed");

	// input side stalls only behind a held result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	// lower bounds never exceed upper bounds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> box_min_x <= box_max_x && box_min_y <= box_max_y
			&& box_min_z <= box_max_z)
		else $error("bounds out of order");

endmodule

bind rotated_box_aabb rba_check #(.COORD_WIDTH(COORD_WIDTH)) u_rba_check (.*);
